>>> sv/gqau_pkg.sv
// Package for the gyro quaternion attitude update core.
// Holds the fixed-point constants, the sequencer and MAC codes, the atan table and rounding.
// No dependencies.
package gqau_pkg;

  localparam int CORDIC_STEPS = 24;

  localparam logic [1:0] REG_QW = 2'd0;
  localparam logic [1:0] REG_QX = 2'd1;
  localparam logic [1:0] REG_QY = 2'd2;
  localparam logic [1:0] REG_QZ = 2'd3;

  localparam logic [1:0] Q_W = 2'd0;
  localparam logic [1:0] Q_X = 2'd1;
  localparam logic [1:0] Q_Y = 2'd2;
  localparam logic [1:0] Q_Z = 2'd3;

  localparam logic [1:0] AX_ROLL  = 2'd0;
  localparam logic [1:0] AX_PITCH = 2'd1;
  localparam logic [1:0] AX_YAW   = 2'd2;

  localparam logic signed [31:0] ONE_Q30        = 32'sh4000_0000;
  localparam logic [27:0]        HALF_ANGLE_Q32 = 28'd157205284;
  localparam logic signed [33:0] DEG90_Q24      = 34'sd1509949440;
  localparam logic signed [26:0] DEG90_Q16      = 27'sd5898240;
  localparam logic signed [26:0] DEG180_Q16     = 27'sd11796480;
  localparam logic signed [26:0] DEG360_Q16     = 27'sd23592960;

  typedef enum logic [3:0] {
    S_IDLE, S_HALF, S_INC, S_NSHIFT, S_NSQ, S_SQINIT, S_SQRT, S_DIVI, S_DIV,
    S_EPROD, S_PSQ, S_CINIT, S_CITER, S_CFIN, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MAC_NONE, MAC_LOAD, MAC_LOADN, MAC_ADD, MAC_SUB, MAC_ADDSH
  } mac_op_t;

  // atan(2^-i) in degrees, Q.24
  function automatic logic [31:0] atan_deg(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd754974720;
      5'd1:  r = 32'd445687602;
      5'd2:  r = 32'd235489088;
      5'd3:  r = 32'd119537938;
      5'd4:  r = 32'd60000934;
      5'd5:  r = 32'd30029717;
      5'd6:  r = 32'd15018523;
      5'd7:  r = 32'd7509720;
      5'd8:  r = 32'd3754917;
      5'd9:  r = 32'd1877466;
      5'd10: r = 32'd938734;
      5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;
      5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;
      5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;
      5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;
      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;
      5'd21: r = 32'd458;
      5'd22: r = 32'd229;
      5'd23: r = 32'd115;
      5'd24: r = 32'd57;
      5'd25: r = 32'd29;
      5'd26: r = 32'd14;
      5'd27: r = 32'd7;
      5'd28: r = 32'd4;
      5'd29: r = 32'd2;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // Right shift by s, rounded to nearest with ties away from zero.
  function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                   input logic [5:0] s);
    logic [65:0] mag;
    logic [65:0] r;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = (mag + (66'd1 << (s - 6'd1))) >> s;
    return v[65] ? -$signed(r) : $signed(r);
  endfunction

endpackage

>>> sv/gyro_quaternion_attitude_update_core.sv
// Top level of the gyro quaternion attitude update core: sequencer and shared datapath.
// Depends on gqau_pkg for constants, state and MAC codes, the atan table and rounding.
//
//   channel | direction | handshake              | word
//   --------+-----------+------------------------+------------------------------------------
//   config  | in        | APB psel/penable/pready| init_qw..init_qz at 0x0, 0x4, 0x8, 0xC
//   input   | in        | in_valid / in_ready    | kind, rate_x, rate_y, rate_z, step_us
//   result  | out       | out_valid / out_ready  | att_w..att_z, roll/pitch/yaw angles
//
// One input word is worked on at a time by a single 33x33 multiply-accumulate unit, a
// bit-serial square root, a restoring divider and one CORDIC rotator, all under the
// sequencer below. Normalizing shifts move a single bit at a time; for a reload or a gyro
// update the square roots, the four 32-step divisions and the three CORDIC runs do most
// of the work. in_ready is high only while the sequencer is idle. The result register
// lets a finished word wait for out_ready while the next input word is processed.
// Synchronous reset restores the identity quaternion and the reset register values.
module gyro_quaternion_attitude_update_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  input  logic [19:0]        step_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] att_w,
  output logic signed [31:0] att_x,
  output logic signed [31:0] att_y,
  output logic signed [31:0] att_z,
  output logic signed [24:0] roll_angle,
  output logic signed [23:0] pitch_angle,
  output logic signed [24:0] yaw_angle
);
  import gqau_pkg::*;

  state_t state, state_next;

  // Configuration registers and attitude state.
  logic [31:0]        cfg  [4];
  logic signed [31:0] quat [4];

  // Latched input word.
  logic signed [15:0] rate_q [3];
  logic [19:0]        step_q;

  // Sequencer counters: idx walks MAC terms, cnt walks iterations, sel picks a lane.
  logic [3:0] idx;
  logic [5:0] cnt;
  logic [1:0] sel;
  logic       phase;  // set once the pitch square root is under way

  // Shared multiply-accumulate unit.
  mac_op_t            mop;
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [65:0] acc;

  // Half angles.
  logic [35:0]        pmag;
  logic               pneg;
  logic signed [31:0] h [3];
  logic [64:0]        hsum;

  // Normalization.
  logic [41:0] m [4];
  logic        sgn [4];
  logic        all_zero, any_big, any_b30;
  logic [63:0] sq_rem, sq_res, sq_bit;
  logic [64:0] sq_trial;
  logic [31:0] nroot;
  logic [31:0] drem, dlow, dq;
  logic [32:0] drem2;
  logic        dbit;
  logic [31:0] dqfin, dclamp;
  logic [61:0] dnum;

  // Euler angle terms: sin/cos of roll, sin/cos of yaw, sin of pitch.
  logic signed [34:0] e [5];
  logic [30:0]        cp;
  logic signed [65:0] rr;
  logic signed [41:0] inc_sum;
  logic signed [34:0] eval;

  // CORDIC rotator.
  logic signed [37:0] cx, cy, x0, y0, cdx, cdy;
  logic signed [33:0] cz, atan_z;
  logic               c_zero;
  logic signed [26:0] ang, ang_off;

  logic signed [24:0] roll_q, yaw_q;
  logic signed [23:0] pitch_q;

  // Term tables for the increment and the Euler products.
  logic [1:0] k, j;
  logic       t_neg;
  logic [1:0] t_qa, t_qb;

  function automatic logic [41:0] mag42(input logic signed [41:0] a);
    return a[41] ? 42'(-a) : 42'(a);
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] a);
    return {a[31], a};
  endfunction

  assign pready = 1'b1;
  assign prdata = cfg[paddr[3:2]];
  assign in_ready = (state == S_IDLE);

  assign k = idx[3:2];
  assign j = idx[1:0];

  assign prod = ma * mb;

  // Increment table: {negate, quaternion part, half-angle axis} for term j of output k.
  always_comb begin
    t_neg = 1'b0;
    t_qa  = Q_W;
    t_qb  = Q_W;
    if (state == S_INC) begin
      case ({k, j})
        4'b00_00: begin t_neg = 1'b1; t_qa = Q_X; t_qb = 2'd0; end
        4'b00_01: begin t_neg = 1'b1; t_qa = Q_Y; t_qb = 2'd1; end
        4'b00_10: begin t_neg = 1'b1; t_qa = Q_Z; t_qb = 2'd2; end
        4'b01_00: begin t_qa = Q_W; t_qb = 2'd0; end
        4'b01_01: begin t_qa = Q_Y; t_qb = 2'd2; end
        4'b01_10: begin t_neg = 1'b1; t_qa = Q_Z; t_qb = 2'd1; end
        4'b10_00: begin t_qa = Q_W; t_qb = 2'd1; end
        4'b10_01: begin t_qa = Q_Z; t_qb = 2'd0; end
        4'b10_10: begin t_neg = 1'b1; t_qa = Q_X; t_qb = 2'd2; end
        4'b11_00: begin t_qa = Q_W; t_qb = 2'd2; end
        4'b11_01: begin t_qa = Q_X; t_qb = 2'd1; end
        4'b11_10: begin t_neg = 1'b1; t_qa = Q_Y; t_qb = 2'd0; end
        default: ;
      endcase
    end else begin
      case ({cnt[2:0], j[0]})
        4'b000_0: begin t_qa = Q_W; t_qb = Q_X; end
        4'b000_1: begin t_qa = Q_Y; t_qb = Q_Z; end
        4'b001_0: begin t_qa = Q_X; t_qb = Q_X; end
        4'b001_1: begin t_qa = Q_Y; t_qb = Q_Y; end
        4'b010_0: begin t_qa = Q_W; t_qb = Q_Z; end
        4'b010_1: begin t_qa = Q_X; t_qb = Q_Y; end
        4'b011_0: begin t_qa = Q_Y; t_qb = Q_Y; end
        4'b011_1: begin t_qa = Q_Z; t_qb = Q_Z; end
        4'b100_0: begin t_qa = Q_W; t_qb = Q_Y; end
        4'b100_1: begin t_neg = 1'b1; t_qa = Q_Z; t_qb = Q_X; end
        default: ;
      endcase
    end
  end

  // Flags and combinational helpers for the datapath.
  always_comb begin
    all_zero = 1'b1;
    any_big  = 1'b0;
    any_b30  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (m[i] != '0) all_zero = 1'b0;
      if (m[i][41:31] != '0) any_big = 1'b1;
      if (m[i][30]) any_b30 = 1'b1;
    end

    hsum     = {1'b0, acc[63:0]} + 65'h0_8000_0000;
    sq_bit   = 64'd1 << (7'd62 - 7'({cnt, 1'b0}));
    sq_trial = {1'b0, sq_res} + {1'b0, sq_bit};

    drem2  = {drem, dlow[31]};
    dbit   = (drem2 >= {1'b0, nroot});
    dqfin  = {dq[30:0], dbit};
    dclamp = (dqfin > 32'(ONE_Q30)) ? 32'(ONE_Q30) : dqfin;
    // Dividend m * 2^30 plus half the root, so the quotient comes out rounded.
    dnum   = {1'b0, m[sel][30:0], 30'd0} + {31'd0, nroot[31:1]};

    inc_sum = {{10{quat[k][31]}}, quat[k]} + rr[41:0];
    eval    = rr[34:0];
    if (cnt[2:0] == 3'd1 || cnt[2:0] == 3'd3) eval = 35'(ONE_Q30) - rr[34:0];
    if (cnt[2:0] == 3'd4) begin
      if (eval > 35'(ONE_Q30)) eval = 35'(ONE_Q30);
      if (eval < -35'(ONE_Q30)) eval = -35'(ONE_Q30);
    end

    unique case (sel)
      AX_ROLL:  begin y0 = 38'(e[0]); x0 = 38'(e[1]); end
      AX_PITCH: begin y0 = 38'(e[4]); x0 = {7'd0, cp}; end
      default:  begin y0 = 38'(e[2]); x0 = 38'(e[3]); end
    endcase
    c_zero = (x0 == '0) && (y0 == '0);

    cdx    = cy >>> cnt[4:0];
    cdy    = cx >>> cnt[4:0];
    atan_z = 34'(atan_deg(cnt[4:0]));

    ang     = rr[26:0];
    ang_off = ang - DEG90_Q16;
    if (ang_off <= -DEG180_Q16) ang_off = ang_off + DEG360_Q16;
    else if (ang_off > DEG180_Q16) ang_off = ang_off - DEG360_Q16;
  end

  // Sequencer: next state and MAC control.
  always_comb begin
    state_next = state;
    mop = MAC_NONE;
    ma  = '0;
    mb  = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind) state_next = S_NSHIFT;
          else if (step_us == '0) state_next = S_EPROD;
          else state_next = S_HALF;
        end
      end
      S_HALF: begin
        case (idx)
          4'd0: begin
            mop = MAC_LOAD;
            ma  = 33'(rate_q[sel]);
            mb  = {13'd0, step_q};
          end
          4'd2: begin
            mop = MAC_LOAD;
            ma  = {15'd0, pmag[17:0]};
            mb  = {5'd0, HALF_ANGLE_Q32};
          end
          4'd3: begin
            mop = MAC_ADDSH;
            ma  = {15'd0, pmag[35:18]};
            mb  = {5'd0, HALF_ANGLE_Q32};
          end
          default: ;
        endcase
        if (idx == 4'd4 && sel == 2'd2) state_next = S_INC;
      end
      S_INC: begin
        if (j != 2'd3) begin
          if (j == 2'd0) mop = t_neg ? MAC_LOADN : MAC_LOAD;
          else mop = t_neg ? MAC_SUB : MAC_ADD;
          ma = sx33(quat[t_qa]);
          mb = sx33(h[t_qb]);
        end
        if (idx == 4'd15) state_next = S_NSHIFT;
      end
      S_NSHIFT: begin
        if (all_zero) state_next = S_EPROD;
        else if (!any_big && any_b30) state_next = S_NSQ;
      end
      S_NSQ: begin
        mop = (idx == 4'd0) ? MAC_LOAD : MAC_ADD;
        ma  = {2'd0, m[idx[1:0]][30:0]};
        mb  = {2'd0, m[idx[1:0]][30:0]};
        if (idx == 4'd3) state_next = S_SQINIT;
      end
      S_SQINIT: state_next = S_SQRT;
      S_SQRT: begin
        if (cnt == 6'd31) state_next = phase ? S_CINIT : S_DIVI;
      end
      S_DIVI: state_next = S_DIV;
      S_DIV: begin
        if (cnt == 6'd31) state_next = (sel == 2'd3) ? S_EPROD : S_DIVI;
      end
      S_EPROD: begin
        if (j != 2'd2) begin
          if (j == 2'd0) mop = MAC_LOAD;
          else mop = t_neg ? MAC_SUB : MAC_ADD;
          ma = sx33(quat[t_qa]);
          mb = sx33(quat[t_qb]);
        end
        if (j == 2'd2 && cnt[2:0] == 3'd4) state_next = S_PSQ;
      end
      S_PSQ: begin
        mop = MAC_LOAD;
        ma  = e[4][32:0];
        mb  = e[4][32:0];
        state_next = S_SQINIT;
      end
      S_CINIT: state_next = c_zero ? S_CFIN : S_CITER;
      S_CITER: begin
        if (cnt == 6'(CORDIC_STEPS - 1)) state_next = S_CFIN;
      end
      S_CFIN: state_next = (sel == AX_YAW) ? S_DONE : S_CINIT;
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg[REG_QW] <= ONE_Q30;
      cfg[REG_QX] <= '0;
      cfg[REG_QY] <= '0;
      cfg[REG_QZ] <= '0;
      quat[Q_W]   <= ONE_Q30;
      quat[Q_X]   <= '0;
      quat[Q_Y]   <= '0;
      quat[Q_Z]   <= '0;
      out_valid   <= 1'b0;
      idx         <= '0;
      cnt         <= '0;
      sel         <= '0;
      phase       <= 1'b0;
    end else begin
      if (psel && penable && pwrite) cfg[paddr[3:2]] <= pwdata;

      case (mop)
        MAC_LOAD:  acc <= prod;
        MAC_LOADN: acc <= -prod;
        MAC_ADD:   acc <= acc + prod;
        MAC_SUB:   acc <= acc - prod;
        MAC_ADDSH: acc <= acc + (prod <<< 18);
        default: ;
      endcase

      // The result register fills from S_DONE and empties when the word is taken.
      if (state == S_DONE && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rate_q[0] <= rate_x;
            rate_q[1] <= rate_y;
            rate_q[2] <= rate_z;
            step_q    <= step_us;
            phase     <= 1'b0;
            idx       <= '0;
            cnt       <= '0;
            sel       <= '0;
            if (kind) begin
              for (int i = 0; i < 4; i++) begin
                m[i]   <= mag42(42'($signed(cfg[i])));
                sgn[i] <= cfg[i][31];
              end
            end
          end
        end
        S_HALF: begin
          if (idx == 4'd1) begin
            pneg <= acc[65];
            pmag <= acc[65] ? 36'(-acc) : acc[35:0];
          end
          if (idx == 4'd4) begin
            h[sel] <= pneg ? -$signed(hsum[63:32]) : $signed(hsum[63:32]);
            idx    <= '0;
            sel    <= (sel == 2'd2) ? 2'd0 : sel + 2'd1;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        S_INC: begin
          if (j == 2'd3) begin
            m[k]   <= mag42(inc_sum);
            sgn[k] <= inc_sum[41];
          end
          idx <= idx + 4'd1;
        end
        S_NSHIFT: begin
          idx <= '0;
          cnt <= '0;
          if (all_zero) begin
            quat[Q_W] <= ONE_Q30;
            quat[Q_X] <= '0;
            quat[Q_Y] <= '0;
            quat[Q_Z] <= '0;
          end else if (any_big) begin
            for (int i = 0; i < 4; i++) m[i] <= m[i] >> 1;
          end else if (!any_b30) begin
            for (int i = 0; i < 4; i++) m[i] <= m[i] << 1;
          end
        end
        S_NSQ: begin
          idx <= (idx == 4'd3) ? 4'd0 : idx + 4'd1;
        end
        S_SQINIT: begin
          sq_rem <= phase ? (64'h1000_0000_0000_0000 - acc[63:0]) : acc[63:0];
          sq_res <= '0;
          cnt    <= '0;
        end
        S_SQRT: begin
          if ({1'b0, sq_rem} >= sq_trial) begin
            sq_rem <= sq_rem - sq_trial[63:0];
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          if (cnt == 6'd31) begin
            cnt <= '0;
            sel <= '0;
            // The last step's result is formed here without the register round trip.
            if (phase) begin
              cp <= ({1'b0, sq_rem} >= sq_trial) ? 31'((sq_res >> 1) + sq_bit)
                                                 : 31'(sq_res >> 1);
            end else begin
              nroot <= ({1'b0, sq_rem} >= sq_trial) ? 32'((sq_res >> 1) + sq_bit)
                                                    : 32'(sq_res >> 1);
            end
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DIVI: begin
          drem <= {2'd0, dnum[61:32]};
          dlow <= dnum[31:0];
          dq   <= '0;
          cnt  <= '0;
        end
        S_DIV: begin
          drem <= dbit ? 32'(drem2 - {1'b0, nroot}) : drem2[31:0];
          dlow <= dlow << 1;
          dq   <= dqfin;
          if (cnt == 6'd31) begin
            quat[sel] <= sgn[sel] ? -$signed(dclamp) : $signed(dclamp);
            sel <= sel + 2'd1;
            cnt <= '0;
            idx <= '0;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_EPROD: begin
          if (j == 2'd2) begin
            e[cnt[2:0]] <= eval;
            idx <= '0;
            cnt <= (cnt[2:0] == 3'd4) ? 6'd0 : cnt + 6'd1;
          end else begin
            idx <= idx + 4'd1;
          end
        end
        S_PSQ: begin
          phase <= 1'b1;
        end
        S_CINIT: begin
          cnt <= '0;
          if (x0[37]) begin
            // Left half plane: turn by 90 degrees toward the positive x axis.
            if (!y0[37]) begin
              cx <= y0;
              cy <= -x0;
              cz <= DEG90_Q24;
            end else begin
              cx <= -y0;
              cy <= x0;
              cz <= -DEG90_Q24;
            end
          end else begin
            cx <= x0;
            cy <= y0;
            cz <= '0;
          end
        end
        S_CITER: begin
          if (!cy[37]) begin
            cx <= cx + cdx;
            cy <= cy - cdy;
            cz <= cz + atan_z;
          end else begin
            cx <= cx - cdx;
            cy <= cy + cdy;
            cz <= cz - atan_z;
          end
          cnt <= cnt + 6'd1;
        end
        S_CFIN: begin
          unique case (sel)
            AX_ROLL: roll_q <= ang_off[24:0];
            AX_PITCH: begin
              if (ang > DEG90_Q16) pitch_q <= DEG90_Q16[23:0];
              else if (ang < -DEG90_Q16) pitch_q <= 24'(-DEG90_Q16);
              else pitch_q <= ang[23:0];
            end
            default: yaw_q <= ang_off[24:0];
          endcase
          sel <= (sel == AX_YAW) ? 2'd0 : sel + 2'd1;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            att_w       <= quat[Q_W];
            att_x       <= quat[Q_X];
            att_y       <= quat[Q_Y];
            att_z       <= quat[Q_Z];
            roll_angle  <= roll_q;
            pitch_angle <= pitch_q;
            yaw_angle   <= yaw_q;
          end
        end
        default: ;
      endcase
    end
  end

  // An all-zero CORDIC input leaves the angle at zero degrees.
  always_comb begin
    rr = '0;
    if (state == S_CFIN) rr = rnd_shift(66'(cz), 6'd8);
    else rr = rnd_shift(acc, (state == S_INC) ? 6'd26 : 6'd29);
  end

endmodule

>>> tb/sv/gyro_quaternion_attitude_update_core_chk.sv
// Checker for the gyro quaternion attitude update core: watches the config port and
// both word channels, predicts every result word and compares it. Depends on gqau_pkg.
`timescale 1ns / 100ps

module gyro_quaternion_attitude_update_core_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               kind,
  input  logic signed [15:0] rate_x,
  input  logic signed [15:0] rate_y,
  input  logic signed [15:0] rate_z,
  input  logic [19:0]        step_us,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] att_w,
  input  logic signed [31:0] att_x,
  input  logic signed [31:0] att_y,
  input  logic signed [31:0] att_z,
  input  logic signed [24:0] roll_angle,
  input  logic signed [23:0] pitch_angle,
  input  logic signed [24:0] yaw_angle,
  output int                 fail_count,
  output int                 pending
);
  import gqau_pkg::*;

  typedef struct {
    logic [31:0] w, x, y, z;
    logic [24:0] roll;
    logic [23:0] pitch;
    logic [24:0] yaw;
  } attitude_t;

  localparam longint HALF_ANG = 64'd157205284;
  localparam longint ONE      = 64'sd1073741824;
  localparam longint D90_24   = 64'sd1509949440;
  localparam longint D90_16   = 64'sd5898240;
  localparam longint D180_16  = 64'sd11796480;
  localparam longint D360_16  = 64'sd23592960;

  localparam longint ATAN_DEG [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0};

  longint    att_q [4];
  longint    init_q [4];
  attitude_t expected_att [$];

  function automatic longint unsigned magn(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Rounds to nearest, ties away from zero.
  function automatic longint round_sh(longint v, int s);
    longint unsigned r;
    r = (magn(v) + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Scales to a unit quaternion; an all-zero vector becomes the identity.
  function automatic void renormalize(longint v [4]);
    longint unsigned m [4];
    longint unsigned mx, s, n, r;
    mx = 0;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = magn(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      att_q = '{ONE, 0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
    end
    for (int i = 0; i < 4; i++) s = s + m[i] * m[i];
    n = int_sqrt(s);
    for (int i = 0; i < 4; i++) begin
      r = ((m[i] << 30) + (n >> 1)) / n;
      if (r > 64'(ONE)) r = 64'(ONE);
      att_q[i] = v[i] < 0 ? -longint'(r) : longint'(r);
    end
  endfunction

  function automatic longint half_angle_q26(logic signed [15:0] rate, logic [19:0] st);
    longint p;
    longint unsigned r;
    p = longint'(rate) * longint'({1'b0, st});
    r = (magn(p) * HALF_ANG + (64'd1 << 31)) >> 32;
    return p < 0 ? -longint'(r) : longint'(r);
  endfunction

  // CORDIC vectoring, degrees in Q.24; left half plane is turned by 90 degrees first.
  function automatic longint atan2_q24(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = D90_24;
      end else begin
        x = -y; y = t; z = -D90_24;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + ATAN_DEG[i % 32];
      end else begin
        x = x - dx; y = y + dy; z = z - ATAN_DEG[i % 32];
      end
    end
    return z;
  endfunction

  function automatic longint offset_wrapped(longint a24);
    longint a;
    a = round_sh(a24, 8) - D90_16;
    while (a <= -D180_16) a = a + D360_16;
    while (a > D180_16) a = a - D360_16;
    return a;
  endfunction

  function automatic attitude_t next_attitude(logic k, logic signed [15:0] rx,
                                              logic signed [15:0] ry,
                                              logic signed [15:0] rz, logic [19:0] st);
    longint hx, hy, hz, w, x, y, z, sr, cr, sy, cy, sp, cp, pitch;
    longint v [4];
    attitude_t a;
    if (k) begin
      renormalize(init_q);
    end else if (st != 0) begin
      hx = half_angle_q26(rx, st);
      hy = half_angle_q26(ry, st);
      hz = half_angle_q26(rz, st);
      w = att_q[0]; x = att_q[1]; y = att_q[2]; z = att_q[3];
      v[0] = w + round_sh(-x * hx - y * hy - z * hz, 26);
      v[1] = x + round_sh(w * hx + y * hz - z * hy, 26);
      v[2] = y + round_sh(w * hy + z * hx - x * hz, 26);
      v[3] = z + round_sh(w * hz + x * hy - y * hx, 26);
      renormalize(v);
    end
    w = att_q[0]; x = att_q[1]; y = att_q[2]; z = att_q[3];
    sr = round_sh(w * x + y * z, 29);
    cr = ONE - round_sh(x * x + y * y, 29);
    sy = round_sh(w * z + x * y, 29);
    cy = ONE - round_sh(y * y + z * z, 29);
    sp = round_sh(w * y - z * x, 29);
    if (sp > ONE) sp = ONE;
    if (sp < -ONE) sp = -ONE;
    cp = longint'(int_sqrt((64'd1 << 60) - 64'(sp * sp)));
    pitch = round_sh(atan2_q24(sp, cp), 8);
    if (pitch > D90_16) pitch = D90_16;
    if (pitch < -D90_16) pitch = -D90_16;
    a.w = w[31:0]; a.x = x[31:0]; a.y = y[31:0]; a.z = z[31:0];
    a.roll = 25'(offset_wrapped(atan2_q24(sr, cr)));
    a.pitch = pitch[23:0];
    a.yaw = 25'(offset_wrapped(atan2_q24(sy, cy)));
    return a;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t ns: mismatch in %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    attitude_t e;
    if (rst) begin
      att_q = '{ONE, 0, 0, 0};
      init_q = '{ONE, 0, 0, 0};
      expected_att.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_QW: init_q[0] = longint'($signed(pwdata));
          REG_QX: init_q[1] = longint'($signed(pwdata));
          REG_QY: init_q[2] = longint'($signed(pwdata));
          REG_QZ: init_q[3] = longint'($signed(pwdata));
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_att.size() == 0) begin
          report("unexpected result word", att_w, 0);
        end else begin
          e = expected_att.pop_front();
          if (att_w !== e.w) report("att_w", att_w, e.w);
          if (att_x !== e.x) report("att_x", att_x, e.x);
          if (att_y !== e.y) report("att_y", att_y, e.y);
          if (att_z !== e.z) report("att_z", att_z, e.z);
          if (roll_angle !== e.roll) report("roll_angle", roll_angle, e.roll);
          if (pitch_angle !== e.pitch) report("pitch_angle", pitch_angle, e.pitch);
          if (yaw_angle !== e.yaw) report("yaw_angle", yaw_angle, e.yaw);
        end
      end
      if (in_valid && in_ready)
        expected_att.push_back(next_attitude(kind, rate_x, rate_y, rate_z, step_us));
      pending = expected_att.size();
    end
  end

endmodule

>>> tb/sv/gyro_quaternion_attitude_update_core_tb.sv
// Testbench top for the gyro quaternion attitude update core: clock, reset, stimulus
// and verdict. Depends on gqau_pkg, the core and gyro_quaternion_attitude_update_core_chk.
`timescale 1ns / 100ps

module gyro_quaternion_attitude_update_core_tb;
  import gqau_pkg::*;

  // The limit leaves a wide margin over about 1000 words with sender gaps, receiver stalls
  // and the one long hold-off.
  localparam int CYCLE_LIMIT = 3_000_000;
  // Extra cycles waited once no word is pending, before a register write or the verdict.
  localparam int DRAIN_CYCLES = 500;

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite, pready;
  logic [3:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               in_valid, in_ready, kind;
  logic signed [15:0] rate_x, rate_y, rate_z;
  logic [19:0]        step_us;
  logic               out_valid, out_ready;
  logic signed [31:0] att_w, att_x, att_y, att_z;
  logic signed [24:0] roll_angle, yaw_angle;
  logic signed [23:0] pitch_angle;
  int                 fail_count, pending;
  int                 cycle_count = 0;
  int                 words_sent = 0;
  int                 burst_left;

  gyro_quaternion_attitude_update_core uut (.*);

  gyro_quaternion_attitude_update_core_chk chk (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && in_valid && in_ready) words_sent <= words_sent + 1;

  // The receiver switches among stall habits: always ready, a coin flip, or mostly stalled.
  // Once, after a few hundred words, it holds off for a long stretch so the result register
  // fills and the core has to drop in_ready.
  initial begin
    int stall_mode;
    int hold_cycles;
    bit held;
    stall_mode = 0;
    hold_cycles = 0;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if ((cycle_count % 64) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready = 1'b0;
      end else if (!held && words_sent >= 400) begin
        held = 1;
        hold_cycles = 3000;
        out_ready = 1'b0;
      end else begin
        case (stall_mode)
          0: out_ready = 1'b1;
          1: out_ready = 1'($urandom_range(0, 1));
          default: out_ready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // APB write: setup cycle, then access cycle; called and returns at a falling edge.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic load_init_quat(logic [31:0] w, logic [31:0] x, logic [31:0] y,
                                logic [31:0] z);
    write_reg(REG_QW, w);
    write_reg(REG_QX, x);
    write_reg(REG_QY, y);
    write_reg(REG_QZ, z);
  endtask

  // Sends one input word in bursts with random gaps between them. The payload stays put
  // until in_ready is seen high at the falling edge ahead of the accepting rising edge.
  task automatic send_word(logic k, logic [15:0] rx, logic [15:0] ry, logic [15:0] rz,
                           logic [19:0] st);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 30)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    kind = k;
    rate_x = rx;
    rate_y = ry;
    rate_z = rz;
    step_us = st;
    in_valid = 1'b1;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  // Lets everything drain so a register write sees the core idle.
  task automatic wait_idle();
    in_valid = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly plausible gyro updates, with full-range rates and steps mixed in and some
  // reloads, so the attitude wanders over the whole sphere.
  task automatic send_random_word();
    logic        k;
    logic [15:0] r [3];
    logic [19:0] st;
    int          sel;
    k = ($urandom_range(0, 99) < 12);
    for (int i = 0; i < 3; i++) begin
      sel = $urandom_range(0, 3);
      if (sel == 0) r[i] = 16'($urandom);
      else if (sel == 1) r[i] = 16'($signed($urandom_range(0, 400)) - 200);
      else r[i] = 16'($signed($urandom_range(0, 16000)) - 8000);
    end
    sel = $urandom_range(0, 9);
    if (sel == 0) st = 20'd0;
    else if (sel < 4) st = 20'($urandom);
    else st = 20'($urandom_range(1, 20000));
    send_word(k, r[0], r[1], r[2], st);
  endtask

  initial begin
    logic [31:0] v [4];
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    kind = 1'b0;
    rate_x = '0;
    rate_y = '0;
    rate_z = '0;
    step_us = '0;
    burst_left = 0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed part: reload of the reset values, zero time step, the rate and step
    // extremes, and reloads that hit gimbal lock and the all-zero vector.
    send_word(1'b1, 16'h7fff, 16'h8000, 16'h1234, 20'hfffff);
    send_word(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 20'd0);
    send_word(1'b0, 16'h7fff, 16'h7fff, 16'h7fff, 20'hfffff);
    send_word(1'b0, 16'h8000, 16'h8000, 16'h8000, 20'hfffff);
    send_word(1'b0, 16'h0010, 16'h0000, 16'h0000, 20'd1);
    send_word(1'b0, 16'h0000, 16'h0000, 16'h0000, 20'd1000);
    send_word(1'b0, 16'h0000, 16'h05a0, 16'h0000, 20'd500000);
    send_word(1'b0, 16'hffff, 16'h0001, 16'h7fff, 20'h80000);
    wait_idle();
    // Pitch at +90 degrees: roll and yaw atan2 lose their argument.
    load_init_quat(32'h4000_0000, 32'h0, 32'h4000_0000, 32'h0);
    send_word(1'b1, 16'h0, 16'h0, 16'h0, 20'h0);
    send_word(1'b0, 16'h0, 16'h0, 16'h0, 20'h0);
    wait_idle();
    load_init_quat(32'h4000_0000, 32'h0, 32'hc000_0000, 32'h0);
    send_word(1'b1, 16'h0, 16'h0, 16'h0, 20'h0);
    wait_idle();
    // All registers zero: the reload falls back to the identity.
    load_init_quat(32'h0, 32'h0, 32'h0, 32'h0);
    send_word(1'b1, 16'h0, 16'h0, 16'h0, 20'h0);
    send_word(1'b0, 16'h1000, 16'hf000, 16'h0800, 20'd20000);
    wait_idle();
    load_init_quat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(1'b1, 16'h0, 16'h0, 16'h0, 20'h0);
    wait_idle();
    load_init_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(1'b1, 16'h0, 16'h0, 16'h0, 20'h0);
    send_word(1'b0, 16'h0100, 16'h0200, 16'h0300, 20'd1000);
    wait_idle();
    load_init_quat(32'h0, 32'h0, 32'h0, 32'h0000_0001);
    send_word(1'b1, 16'h0, 16'h0, 16'h0, 20'h0);
    wait_idle();

    // Random part: phases of about 125 words, each with fresh register contents.
    for (int phase = 0; phase < 8; phase++) begin
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0: v[i] = $urandom;
          1: v[i] = 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
          2: v[i] = ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
          default: v[i] = $urandom_range(0, 255);
        endcase
      end
      load_init_quat(v[0], v[1], v[2], v[3]);
      send_word(1'b1, 16'($urandom), 16'($urandom), 16'($urandom), 20'($urandom));
      repeat (125) send_random_word();
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/gqau_pkg.sv
sv/gyro_quaternion_attitude_update_core.sv
tb/sv/gyro_quaternion_attitude_update_core_chk.sv
tb/sv/gyro_quaternion_attitude_update_core_tb.sv
